/* hw/rtl/accel_tilt_angles_macros.svh */
// Assertion macros used by the tilt angle RTL.
// Each use names a label, the clock, the reset, a condition, the expected
// consequence and a message.
`ifndef ACCEL_TILT_ANGLES_MACROS_SVH
`define ACCEL_TILT_ANGLES_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ATA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ATA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ATA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define ATA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* hw/rtl/ata_pkg.sv */
package ata_pkg;

   // sample and step counts
   parameter int SAMPLE_WIDTH = 16;
   parameter int CORDIC_STEPS = 16;
   parameter int SCALE_BITS   = 32 - SAMPLE_WIDTH;

   // square root datapath: radicand is the sum of squares shifted to the top of 64 bits
   parameter int SQ_W   = 2 * SAMPLE_WIDTH;
   parameter int ROOT_W = 32;
   parameter int REM_W  = ROOT_W + 4;

   // CORDIC datapath: room for the scaled root times the CORDIC gain
   parameter int COORD_W = 35;
   parameter int ANGLE_W = 16;
   parameter int TAG_W   = 16;

   parameter int HALF_PI_UNITS = 16384;
   parameter int TABLE_LEN     = 24;
   parameter int STEP_W        = $clog2(TABLE_LEN);

   // pipeline shape
   parameter int PITCH_DLY  = ROOT_W - CORDIC_STEPS;
   parameter int NUM_STAGES = 2 + ROOT_W + CORDIC_STEPS;

   // output queue
   parameter int Q_DEPTH = 2;
   parameter int Q_CNT_W = $clog2(Q_DEPTH + 1);
   parameter int Q_PTR_W = $clog2(Q_DEPTH);

   // atan(2^-i) in units of pi/32768, rounded
   parameter logic signed [ANGLE_W-1:0] STEP_ANGLE [TABLE_LEN] = '{
      16'sd8192, 16'sd4836, 16'sd2555, 16'sd1297, 16'sd651, 16'sd326, 16'sd163, 16'sd81,
      16'sd41,   16'sd20,   16'sd10,   16'sd5,    16'sd3,   16'sd1,   16'sd1,   16'sd0,
      16'sd0,    16'sd0,    16'sd0,    16'sd0,    16'sd0,   16'sd0,   16'sd0,   16'sd0
   };

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [SQ_W-1:0]   rad;
   } sqrt_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [ANGLE_W-1:0] z;
      logic                      is_zero;
      logic                      is_half;
      logic                      is_pos;
   } cordic_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] accel_y;
      logic [TAG_W-1:0]               tag;
   } pass_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] pitch;
      logic [TAG_W-1:0]          tag;
   } tail_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] roll;
      logic signed [ANGLE_W-1:0] pitch;
      logic [TAG_W-1:0]          tag;
   } result_type;

   // sign-extend a sample (one spare bit for negation) and scale it up
   function automatic logic signed [COORD_W-1:0] scale_up(
      input logic signed [SAMPLE_WIDTH:0] v);
      logic signed [COORD_W-1:0] wide;
      wide = COORD_W'(v);
      return wide <<< SCALE_BITS;
   endfunction

   // resolve the degenerate vectors and clamp to +-pi/2
   function automatic logic signed [ANGLE_W-1:0] cordic_finish(input cordic_type c);
      logic signed [ANGLE_W-1:0] half;
      logic signed [ANGLE_W-1:0] ang;
      half = ANGLE_W'(HALF_PI_UNITS);
      if (c.is_zero) begin
         ang = '0;
      end else if (c.is_half) begin
         ang = c.is_pos ? half : -half;
      end else if (c.z > half) begin
         ang = half;
      end else if (c.z < -half) begin
         ang = -half;
      end else begin
         ang = c.z;
      end
      return ang;
   endfunction

endpackage

/* hw/rtl/accel_tilt_angles.sv */
// Roll and pitch from one accelerometer sample per transaction.
// Stages from acceptance to the output queue: 2 input stages, 32 square root
// cells, 16 roll CORDIC cells; pitch CORDIC runs beside the square root cells.
// Throughput: one transaction per cycle while the 2-entry output queue, which decouples
// rsp_stall, has room. Reset (synchronous, active high) empties the pipeline and queue.
`include "accel_tilt_angles_macros.svh"

module accel_tilt_angles (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [ata_pkg::SAMPLE_WIDTH-1:0] req_accel_x,
   input  logic signed [ata_pkg::SAMPLE_WIDTH-1:0] req_accel_y,
   input  logic signed [ata_pkg::SAMPLE_WIDTH-1:0] req_accel_z,
   input  logic [ata_pkg::TAG_W-1:0]            req_sample_tag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [ata_pkg::ANGLE_W-1:0]   rsp_roll_angle,
   output logic signed [ata_pkg::ANGLE_W-1:0]   rsp_pitch_angle,
   output logic [ata_pkg::TAG_W-1:0]            rsp_tag_out
);

   localparam int SW = ata_pkg::SAMPLE_WIDTH;

   logic adv;
   logic push;
   logic pop;

   logic [ata_pkg::NUM_STAGES-1:0] vld_ff;

   // stage 0: captured sample and squares
   logic signed [SW-1:0]     ax0_ff, ay0_ff, az0_ff;
   logic [ata_pkg::TAG_W-1:0] tag0_ff;
   logic signed [2*SW-1:0]   xx0_ff, zz0_ff;

   // stage 1: sum of squares and pitch start vector
   logic [ata_pkg::SQ_W-1:0]  sq1_ff, sq1_in;
   ata_pkg::cordic_type       pit1_ff, pit1_in;
   logic signed [SW-1:0]      ay1_ff;
   logic [ata_pkg::TAG_W-1:0] tag1_ff;
   logic signed [SW:0]        ax_ext, az_ext, px17, py17;

   // cell chains
   ata_pkg::sqrt_type   sqrt_link [ata_pkg::ROOT_W+1];
   ata_pkg::cordic_type pit_link  [ata_pkg::CORDIC_STEPS+1];
   ata_pkg::cordic_type roll_link [ata_pkg::CORDIC_STEPS+1];

   // side data travelling with the chains
   ata_pkg::pass_type   pass_ff [ata_pkg::ROOT_W];
   logic signed [ata_pkg::ANGLE_W-1:0] pdly_ff [ata_pkg::PITCH_DLY];
   ata_pkg::tail_type   tail_ff [ata_pkg::CORDIC_STEPS];
   logic signed [SW:0]  ay_ext;
   ata_pkg::cordic_type roll_start;

   // output queue
   ata_pkg::result_type        q_data_ff [ata_pkg::Q_DEPTH];
   ata_pkg::result_type        q_wdata;
   logic [ata_pkg::Q_CNT_W-1:0] q_cnt_ff, q_cnt_in;
   logic [ata_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ata_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;

   // pipeline moves whenever the queue has room
   assign adv       = (q_cnt_ff != ata_pkg::Q_CNT_W'(ata_pkg::Q_DEPTH));
   assign req_stall = !adv;
   assign push      = adv && vld_ff[ata_pkg::NUM_STAGES-1];
   assign rsp_valid = (q_cnt_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;

   // valid shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ata_pkg::NUM_STAGES-2:0], req_valid};
      end
   end

   // stage 0: sample capture and squaring
   always_ff @(posedge clock) begin
      if (adv) begin
         ax0_ff  <= req_accel_x;
         ay0_ff  <= req_accel_y;
         az0_ff  <= req_accel_z;
         tag0_ff <= req_sample_tag;
         xx0_ff  <= req_accel_x * req_accel_x;
         zz0_ff  <= req_accel_z * req_accel_z;
      end
   end

   // stage 1: sum of squares, pitch vector as atan2 with x >= 0
   always_comb begin
      sq1_in  = ata_pkg::SQ_W'(xx0_ff) + ata_pkg::SQ_W'(zz0_ff);
      ax_ext  = {ax0_ff[SW-1], ax0_ff};
      az_ext  = {az0_ff[SW-1], az0_ff};
      px17    = az_ext[SW] ? -az_ext : az_ext;
      py17    = az_ext[SW] ? ax_ext : -ax_ext;
      pit1_in.x       = ata_pkg::scale_up(px17);
      pit1_in.y       = ata_pkg::scale_up(py17);
      pit1_in.z       = '0;
      pit1_in.is_zero = (ax0_ff == '0);
      pit1_in.is_half = (az0_ff == '0) && (ax0_ff != '0);
      pit1_in.is_pos  = !py17[SW] && (py17 != '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq1_ff  <= sq1_in;
         pit1_ff <= pit1_in;
         ay1_ff  <= ay0_ff;
         tag1_ff <= tag0_ff;
      end
   end

   // square root chain
   assign sqrt_link[0] = '{rem: '0, root: '0, rad: sq1_ff};

   for (genvar k = 0; k < ata_pkg::ROOT_W; k++) begin : g_sqrt
      ata_sqrt_cell u_cell (
         .clock     (clock),
         .adv       (adv),
         .root_prev (sqrt_link[k]),
         .root_ff   (sqrt_link[k+1])
      );
   end

   // pitch CORDIC chain, alongside the first square root cells
   assign pit_link[0] = pit1_ff;

   for (genvar j = 0; j < ata_pkg::CORDIC_STEPS; j++) begin : g_pitch
      ata_cordic_cell u_cell (
         .clock    (clock),
         .adv      (adv),
         .step     (ata_pkg::STEP_W'(j)),
         .vec_prev (pit_link[j]),
         .vec_ff   (pit_link[j+1])
      );
   end

   // roll start vector: (root, y) with root >= 0
   always_comb begin
      ay_ext = {pass_ff[ata_pkg::ROOT_W-1].accel_y[SW-1], pass_ff[ata_pkg::ROOT_W-1].accel_y};
      roll_start.x       = ata_pkg::COORD_W'(sqrt_link[ata_pkg::ROOT_W].root);
      roll_start.y       = ata_pkg::scale_up(ay_ext);
      roll_start.z       = '0;
      roll_start.is_zero = (ay_ext == '0);
      roll_start.is_half = (sqrt_link[ata_pkg::ROOT_W].root == '0) && (ay_ext != '0);
      roll_start.is_pos  = !ay_ext[SW] && (ay_ext != '0);
   end

   assign roll_link[0] = roll_start;

   for (genvar j = 0; j < ata_pkg::CORDIC_STEPS; j++) begin : g_roll
      ata_cordic_cell u_cell (
         .clock    (clock),
         .adv      (adv),
         .step     (ata_pkg::STEP_W'(j)),
         .vec_prev (roll_link[j]),
         .vec_ff   (roll_link[j+1])
      );
   end

   // side data delay lines
   always_ff @(posedge clock) begin
      if (adv) begin
         pass_ff[0] <= '{accel_y: ay1_ff, tag: tag1_ff};
         for (int k = 1; k < ata_pkg::ROOT_W; k++) begin
            pass_ff[k] <= pass_ff[k-1];
         end
         pdly_ff[0] <= ata_pkg::cordic_finish(pit_link[ata_pkg::CORDIC_STEPS]);
         for (int m = 1; m < ata_pkg::PITCH_DLY; m++) begin
            pdly_ff[m] <= pdly_ff[m-1];
         end
         tail_ff[0] <= '{pitch: pdly_ff[ata_pkg::PITCH_DLY-1],
                         tag:   pass_ff[ata_pkg::ROOT_W-1].tag};
         for (int j = 1; j < ata_pkg::CORDIC_STEPS; j++) begin
            tail_ff[j] <= tail_ff[j-1];
         end
      end
   end

   // result assembly
   always_comb begin
      q_wdata.roll  = ata_pkg::cordic_finish(roll_link[ata_pkg::CORDIC_STEPS]);
      q_wdata.pitch = tail_ff[ata_pkg::CORDIC_STEPS-1].pitch;
      q_wdata.tag   = tail_ff[ata_pkg::CORDIC_STEPS-1].tag;
   end

   // output queue control
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   q_cnt_in = q_cnt_ff + 1'b1;
         2'b01:   q_cnt_in = q_cnt_ff - 1'b1;
         default: q_cnt_in = q_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         q_cnt_ff  <= q_cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_data_ff[wr_ptr_ff] <= q_wdata;
      end
   end

   assign rsp_roll_angle  = q_data_ff[rd_ptr_ff].roll;
   assign rsp_pitch_angle = q_data_ff[rd_ptr_ff].pitch;
   assign rsp_tag_out     = q_data_ff[rd_ptr_ff].tag;

   // checks
   `ATA_ASSERT_IMP(a_roll_range, clock, reset, rsp_valid, (rsp_roll_angle <= ata_pkg::HALF_PI_UNITS) && (rsp_roll_angle >= -ata_pkg::HALF_PI_UNITS), "roll angle out of range")
   `ATA_ASSERT_IMP(a_pitch_range, clock, reset, rsp_valid, (rsp_pitch_angle <= ata_pkg::HALF_PI_UNITS) && (rsp_pitch_angle >= -ata_pkg::HALF_PI_UNITS), "pitch angle out of range")
   `ATA_ASSERT_NXT(a_q_drain, clock, reset, (q_cnt_ff == 2'd1) && pop && !push, !rsp_valid, "queue did not drain")
   `ATA_ASSERT_IMP(a_empty_accepts, clock, reset, !rsp_valid, !req_stall, "stall with an empty queue")

endmodule

/* hw/rtl/ata_sqrt_cell.sv */
// One restoring square root step: brings down two radicand bits, settles one root bit.
module ata_sqrt_cell (
   input  logic              clock,
   input  logic              adv,
   input  ata_pkg::sqrt_type root_prev,
   output ata_pkg::sqrt_type root_ff
);

   logic [ata_pkg::REM_W-1:0] rem_sh;
   logic [ata_pkg::REM_W-1:0] trial;
   logic                      fits;
   ata_pkg::sqrt_type         root_in;

   // trial subtract of (4*root + 1)
   always_comb begin
      rem_sh  = {root_prev.rem[ata_pkg::REM_W-3:0], root_prev.rad[ata_pkg::SQ_W-1 -: 2]};
      trial   = ata_pkg::REM_W'({root_prev.root, 2'b01});
      fits    = (rem_sh >= trial);
      root_in.rem  = fits ? (rem_sh - trial) : rem_sh;
      root_in.root = {root_prev.root[ata_pkg::ROOT_W-2:0], fits};
      root_in.rad  = {root_prev.rad[ata_pkg::SQ_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         root_ff <= root_in;
      end
   end

endmodule

/* hw/rtl/ata_cordic_cell.sv */
// One vectoring CORDIC step: rotate toward the x axis by atan(2^-step).
module ata_cordic_cell (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [ata_pkg::STEP_W-1:0]  step,
   input  ata_pkg::cordic_type         vec_prev,
   output ata_pkg::cordic_type         vec_ff
);

   logic signed [ata_pkg::COORD_W-1:0] x_c;
   logic signed [ata_pkg::COORD_W-1:0] y_c;
   logic signed [ata_pkg::COORD_W-1:0] xs;
   logic signed [ata_pkg::COORD_W-1:0] ys;
   logic signed [ata_pkg::ANGLE_W-1:0] ang;
   logic                               y_pos;
   ata_pkg::cordic_type                vec_in;

   // shift-add rotation, direction by the sign of y
   always_comb begin
      x_c   = vec_prev.x;
      y_c   = vec_prev.y;
      xs    = x_c >>> step;
      ys    = y_c >>> step;
      ang   = ata_pkg::STEP_ANGLE[step];
      y_pos = !y_c[ata_pkg::COORD_W-1] && (y_c != '0);
      vec_in = vec_prev;
      if (y_pos) begin
         vec_in.x = x_c + ys;
         vec_in.y = y_c - xs;
         vec_in.z = vec_prev.z + ang;
      end else begin
         vec_in.x = x_c - ys;
         vec_in.y = y_c + xs;
         vec_in.z = vec_prev.z - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vec_ff <= vec_in;
      end
   end

endmodule
